### hw/rtl/scem_pkg.sv
// ---------------------------------------------------------------------------
// scem_pkg
// shared widths, register map and defaults for the cumulative energy map
// ---------------------------------------------------------------------------
package scem_pkg;

  localparam int unsigned ENERGY_W      = 20;
  localparam int unsigned COST_W        = 32;
  localparam int unsigned CFG_W         = 13;
  localparam int unsigned APB_ADDR_W    = 3;
  localparam int unsigned APB_DATA_W    = 32;
  localparam int unsigned MAX_WIDTH_DEF = 4096;
  localparam int unsigned MIN_WIDTH     = 2;

  // register index field of paddr (byte address 4*i)
  localparam int unsigned REG_IDX_W = APB_ADDR_W - 2;
  localparam logic [REG_IDX_W-1:0] REG_IMAGE_WIDTH = '0;

  localparam logic [CFG_W-1:0] IMAGE_WIDTH_RESET = 13'd640;

endpackage

### hw/rtl/scem_if.sv
// ---------------------------------------------------------------------------
// scem_in_if / scem_out_if
// valid/ready channels for energy words in and cumulative cost words out
// ---------------------------------------------------------------------------
interface scem_in_if;
  logic                          valid;
  logic                          ready;
  logic [scem_pkg::ENERGY_W-1:0] energy_value;
  logic                          frame_start;

  modport source (output valid, output energy_value, output frame_start, input ready);
  modport sink   (input valid, input energy_value, input frame_start, output ready);
endinterface

interface scem_out_if;
  logic                        valid;
  logic                        ready;
  logic [scem_pkg::COST_W-1:0] cumulative_energy;
  logic                        row_end;

  modport source (output valid, output cumulative_energy, output row_end, input ready);
  modport sink   (input valid, input cumulative_energy, input row_end, output ready);
endinterface

### hw/rtl/scem_ram.sv
// ---------------------------------------------------------------------------
// scem_ram
// simple dual-port ram, one write and one registered read per cycle
// ---------------------------------------------------------------------------
module scem_ram #(
  parameter int unsigned WIDTH = scem_pkg::COST_W,
  parameter int unsigned DEPTH = scem_pkg::MAX_WIDTH_DEF
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // read returns the old contents on a same-address write
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### hw/rtl/seam_cumulative_energy_map.sv
// ---------------------------------------------------------------------------
// seam_cumulative_energy_map
// cumulative minimum vertical seam energy over a raster energy stream
// ---------------------------------------------------------------------------
// pixel carries one energy word per pixel in raster order; frame_start marks
// row zero column zero. result returns one cumulative cost word per pixel, in
// order, with row_end on the last pixel of each row. image_width (apb, byte
// address 0) sets the row length, clamped to 2..MAX_WIDTH, written while idle.
// An accepted word is registered in the compute stage, then in the output register,
// before it shows on result. Throughput: one word per cycle while result is not stalled.
// The previous row lives in one ram with one read and one write port: each
// pixel reads the entry above-right, the above value comes from the read made
// for the pixel before, column zero comes from its own register.
// A read that hits the entry written on the same edge is forwarded.
// Reset clears the column counter, first-row flag and both handshake stages;
// the line store is not cleared and is valid once the first row is written.
// A stalled receiver holds the output register; one more word is taken into
// the compute stage, then pixel.ready drops until result drains.
// ---------------------------------------------------------------------------
module seam_cumulative_energy_map #(
  parameter int unsigned MAX_WIDTH = scem_pkg::MAX_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst,
  scem_in_if.sink                           pixel,
  scem_out_if.source                        result,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [scem_pkg::APB_ADDR_W-1:0]   paddr,
  input  logic [scem_pkg::APB_DATA_W-1:0]   pwdata,
  output logic [scem_pkg::APB_DATA_W-1:0]   prdata,
  output logic                              pready
);

  localparam int unsigned ADDR_W = $clog2(MAX_WIDTH);
  localparam int unsigned COL_W  = $clog2(MAX_WIDTH + 1);
  localparam int unsigned CMP_W  = (COL_W > scem_pkg::CFG_W) ? COL_W : scem_pkg::CFG_W;
  localparam int unsigned EW     = scem_pkg::ENERGY_W;
  localparam int unsigned CW     = scem_pkg::COST_W;

  // configuration
  logic [scem_pkg::CFG_W-1:0] image_width;
  logic                       reg_sel;

  assign pready  = 1'b1;
  assign reg_sel = (paddr[scem_pkg::APB_ADDR_W-1:2] == scem_pkg::REG_IMAGE_WIDTH);
  assign prdata  = reg_sel ? scem_pkg::APB_DATA_W'(image_width) : '0;

  always_ff @(posedge clk) begin
    if (rst) begin
      image_width <= scem_pkg::IMAGE_WIDTH_RESET;
    end else if (psel && penable && pwrite && pready && reg_sel) begin
      image_width <= pwdata[scem_pkg::CFG_W-1:0];
    end
  end

  logic [CMP_W-1:0] width_ext;
  logic [COL_W-1:0] width_eff;

  assign width_ext = CMP_W'(image_width);

  always_comb begin
    if (width_ext < CMP_W'(scem_pkg::MIN_WIDTH)) begin
      width_eff = COL_W'(scem_pkg::MIN_WIDTH);
    end else if (width_ext > CMP_W'(MAX_WIDTH)) begin
      width_eff = COL_W'(MAX_WIDTH);
    end else begin
      width_eff = COL_W'(width_ext);
    end
  end

  // column tracking at the input
  logic [COL_W-1:0]  column_count, column_count_next;
  logic              first_row_flag, first_row_flag_next;
  logic [COL_W-1:0]  x_col;
  logic              x_first;
  logic              x_last;
  logic [ADDR_W-1:0] x_idx;
  logic [ADDR_W-1:0] rd_addr;
  logic              accept;

  always_comb begin
    if (pixel.frame_start) begin
      x_col   = '0;
      x_first = 1'b1;
    end else if (column_count >= width_eff) begin
      x_col   = '0;
      x_first = 1'b0;
    end else begin
      x_col   = column_count;
      x_first = first_row_flag;
    end
    x_last = (x_col == width_eff - COL_W'(1));
    if (x_last) begin
      column_count_next   = '0;
      first_row_flag_next = 1'b0;
    end else begin
      column_count_next   = x_col + COL_W'(1);
      first_row_flag_next = x_first;
    end
  end

  assign x_idx   = x_col[ADDR_W-1:0];
  assign rd_addr = x_idx + ADDR_W'(1);   // above-right; unused on the last column, wraps there only at MAX_WIDTH
  assign accept  = pixel.valid && pixel.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      column_count   <= '0;
      first_row_flag <= 1'b1;
    end else if (accept) begin
      column_count   <= column_count_next;
      first_row_flag <= first_row_flag_next;
    end
  end

  // compute stage
  logic              b_valid;
  logic [EW-1:0]     b_energy;
  logic [ADDR_W-1:0] b_x;
  logic              b_last;
  logic              b_first;
  logic              b_fwd;
  logic [CW-1:0]     b_fwd_data;
  logic              b_advance;
  logic              b_zero;
  logic [CW-1:0]     rd_data;
  logic [CW-1:0]     col0_value;
  logic [CW-1:0]     next_up;
  logic [CW-1:0]     held_left_value;
  logic [CW-1:0]     up_value, right_value, min_lu, best;
  logic [CW:0]       sum;
  logic [CW-1:0]     b_cost;
  logic              out_valid;
  logic [CW-1:0]     out_cost;
  logic              out_row_end;

  assign b_advance   = b_valid && (!out_valid || result.ready);
  assign pixel.ready = !b_valid || b_advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (accept) begin
      b_valid <= 1'b1;
    end else if (b_advance) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      b_energy   <= pixel.energy_value;
      b_x        <= x_idx;
      b_last     <= x_last;
      b_first    <= x_first;
      // the word leaving this edge writes the entry being read
      b_fwd      <= b_advance && (b_x == rd_addr);
      b_fwd_data <= b_cost;
    end
  end

  scem_ram #(
    .WIDTH (CW),
    .DEPTH (MAX_WIDTH)
  ) u_line (
    .clk   (clk),
    .we    (b_advance),
    .waddr (b_x),
    .wdata (b_cost),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (rd_data)
  );

  assign b_zero      = (b_x == '0);
  assign right_value = b_fwd ? b_fwd_data : rd_data;
  assign up_value    = b_zero ? col0_value : next_up;

  always_comb begin
    if (b_zero) begin
      min_lu = up_value;
    end else begin
      min_lu = (held_left_value < up_value) ? held_left_value : up_value;
    end
    if (b_last) begin
      best = min_lu;
    end else begin
      best = (min_lu < right_value) ? min_lu : right_value;
    end
    sum = {1'b0, best} + (CW + 1)'(b_energy);
    if (b_first) begin
      b_cost = CW'(b_energy);
    end else if (sum[CW]) begin
      b_cost = '1;
    end else begin
      b_cost = sum[CW-1:0];
    end
  end

  // neighbor window carried from word to word
  always_ff @(posedge clk) begin
    if (rst) begin
      held_left_value <= '0;
    end else if (b_advance) begin
      held_left_value <= up_value;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      next_up <= right_value;
      if (b_zero) begin
        col0_value <= b_cost;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (b_advance) begin
      out_valid <= 1'b1;
    end else if (result.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_advance) begin
      out_cost    <= b_cost;
      out_row_end <= b_last;
    end
  end

  assign result.valid             = out_valid;
  assign result.cumulative_energy = out_cost;
  assign result.row_end           = out_row_end;

endmodule

### hw/rtl/scem_checker.sv
// ---------------------------------------------------------------------------
// scem_checker
// port-level checks on the cumulative energy map handshakes
// ---------------------------------------------------------------------------
module scem_checker (
  input logic                        clk,
  input logic                        rst,
  input logic                        in_valid,
  input logic                        in_ready,
  input logic                        out_valid,
  input logic                        out_ready,
  input logic [scem_pkg::COST_W-1:0] out_cost,
  input logic                        out_row_end
);

  // both stages empty after reset
  a_reset_empty: assert property (@(posedge clk)
    rst |=> (!out_valid && in_ready))
    else $error("scem: pipeline not empty after reset");

  // an empty output register never blocks the input
  a_ready_when_out_free: assert property (@(posedge clk) disable iff (rst)
    !out_valid |-> in_ready)
    else $error("scem: input stalled with free output register");

  // an accepted word passes from the compute stage to the output register when the output is free or taken
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) ##1 (!out_valid || out_ready) |=> out_valid)
    else $error("scem: accepted word did not reach output");

  a_stall_hold: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_ready) |=>
      (out_valid && $stable(out_cost) && $stable(out_row_end)))
    else $error("scem: stalled output word changed");

endmodule

bind seam_cumulative_energy_map scem_checker u_scem_checker (
  .clk         (clk),
  .rst         (rst),
  .in_valid    (pixel.valid),
  .in_ready    (pixel.ready),
  .out_valid   (result.valid),
  .out_ready   (result.ready),
  .out_cost    (result.cumulative_energy),
  .out_row_end (result.row_end)
);

### test/tb_seam_cumulative_energy_map.sv
// ---------------------------------------------------------------------------
// tb_seam_cumulative_energy_map
// self-checking bench for the cumulative seam energy map
// ---------------------------------------------------------------------------
// Streams energy words in raster order through the pixel channel and checks
// every cost word on the result channel against an in-bench line-store model.
// A short directed pass covers field extremes, edge and middle columns,
// missing frame_start after reset, clamped widths and a width lowered in
// mid-row. A short full-rate run follows at the top energy. Random
// phases then change image_width over apb between bursts, with random idle
// on both channels, one long receiver hold-off and one drain pause.
// ---------------------------------------------------------------------------
module tb_seam_cumulative_energy_map;

  typedef struct packed {
    logic [scem_pkg::COST_W-1:0] cost;
    logic                        row_end;
  } cost_word_t;

  localparam logic [scem_pkg::APB_ADDR_W-1:0] WIDTH_ADDR = {scem_pkg::REG_IMAGE_WIDTH, 2'b00};
  localparam logic [scem_pkg::ENERGY_W-1:0]   ENERGY_MAX = '1;
  localparam logic [scem_pkg::COST_W-1:0]     COST_MAX   = '1;

  // line-store model of the block plus the queue of cost words still owed
  class seam_cost_board;
    logic [scem_pkg::COST_W-1:0] cost_line[scem_pkg::MAX_WIDTH_DEF];
    bit                          line_known[scem_pkg::MAX_WIDTH_DEF];
    logic [scem_pkg::COST_W-1:0] left_cost;
    bit                          left_known;
    int unsigned                 col;
    bit                          top_row;
    logic [scem_pkg::CFG_W-1:0]  span;
    cost_word_t                  owed[$];
    int                          errors;

    function new();
      foreach (line_known[i]) line_known[i] = 1'b0;
      left_cost  = '0;
      left_known = 1'b0;
      col        = 0;
      top_row    = 1'b1;
      span       = scem_pkg::IMAGE_WIDTH_RESET;
      errors     = 0;
    endfunction

    function void set_span(logic [scem_pkg::CFG_W-1:0] v);
      span = v;
    endfunction

    function int unsigned row_len();
      if (span < scem_pkg::MIN_WIDTH) return scem_pkg::MIN_WIDTH;
      if (span > scem_pkg::MAX_WIDTH_DEF) return scem_pkg::MAX_WIDTH_DEF;
      return span;
    endfunction

    function int pending();
      return owed.size();
    endfunction

    // true when a pixel without frame_start would read a line entry never written
    function bit needs_start();
      int unsigned w;
      int unsigned x;
      bit          t;
      w = row_len();
      x = col;
      t = top_row;
      if (x >= w) begin
        x = 0;
        t = 1'b0;
      end
      if (t) return 1'b0;
      if (x == 0) return !(line_known[0] && line_known[1]);
      if (x == w - 1) return !(left_known && line_known[x]);
      return !(left_known && line_known[x] && line_known[x + 1]);
    endfunction

    function void note_pixel(logic [scem_pkg::ENERGY_W-1:0] energy, bit start);
      int unsigned                 w;
      int unsigned                 x;
      bit                          last;
      logic [scem_pkg::COST_W-1:0] up;
      logic [scem_pkg::COST_W-1:0] best;
      logic [scem_pkg::COST_W:0]   sum;
      cost_word_t                  word;
      w = row_len();
      if (start) begin
        col     = 0;
        top_row = 1'b1;
      end else if (col >= w) begin
        // width was lowered in mid-row: wrap to a new row
        col     = 0;
        top_row = 1'b0;
      end
      x    = col;
      last = (x == w - 1);
      up   = cost_line[x];
      if (top_row) begin
        word.cost = scem_pkg::COST_W'(energy);
      end else begin
        if (x == 0) begin
          best = (up < cost_line[1]) ? up : cost_line[1];
        end else if (last) begin
          best = (left_cost < up) ? left_cost : up;
        end else begin
          best = (up < cost_line[x + 1]) ? up : cost_line[x + 1];
          best = (left_cost < best) ? left_cost : best;
        end
        sum = {1'b0, best} + (scem_pkg::COST_W + 1)'(energy);
        word.cost = sum[scem_pkg::COST_W] ? COST_MAX : sum[scem_pkg::COST_W-1:0];
      end
      word.row_end  = last;
      left_cost     = up;
      left_known    = line_known[x];
      cost_line[x]  = word.cost;
      line_known[x] = 1'b1;
      if (last) begin
        col     = 0;
        top_row = 1'b0;
      end else begin
        col = x + 1;
      end
      owed.push_back(word);
    endfunction

    task report(string msg);
      $display("mismatch: %s", msg);
      errors++;
    endtask

    task check_word(logic [scem_pkg::COST_W-1:0] cost, logic row_end);
      cost_word_t want;
      if (owed.size() == 0) begin
        report($sformatf("cost word %h with none expected", cost));
        return;
      end
      want = owed.pop_front();
      if (cost !== want.cost)
        report($sformatf("cumulative_energy got %h want %h", cost, want.cost));
      if (row_end !== want.row_end)
        report($sformatf("row_end got %b want %b", row_end, want.row_end));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic psel;
  logic penable;
  logic pwrite;
  logic [scem_pkg::APB_ADDR_W-1:0] paddr;
  logic [scem_pkg::APB_DATA_W-1:0] pwdata;
  logic [scem_pkg::APB_DATA_W-1:0] prdata;
  logic pready;

  scem_in_if  pixel_ch();
  scem_out_if result_ch();

  seam_cumulative_energy_map dut (
    .clk     (clk),
    .rst     (rst),
    .pixel   (pixel_ch),
    .result  (result_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  seam_cost_board board = new();
  bit send_idle = 1'b1;
  bit recv_idle = 1'b1;
  int hold_len  = 0;

  always #1 clk = ~clk;

  initial begin
    #400000;
    $display("tb: failure");
    $finish;
  end

  // receiver: random ready gaps, one long hold-off on request
  initial begin
    int gap;
    result_ch.ready <= 1'b0;
    do @(posedge clk); while (rst !== 1'b0);
    forever begin
      if (hold_len > 0) begin
        gap      = hold_len;
        hold_len = 0;
      end else begin
        gap = recv_idle ? $urandom_range(0, 17) : 0;
      end
      if (gap > 0) begin
        result_ch.ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      do @(posedge clk); while (result_ch.valid !== 1'b1);
      board.check_word(result_ch.cumulative_energy, result_ch.row_end);
    end
  end

  task automatic send_pixel(input logic [scem_pkg::ENERGY_W-1:0] energy, input bit fs);
    int gap;
    bit start;
    gap = send_idle ? $urandom_range(0, 17) : 0;
    if (gap > 0) begin
      pixel_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    start = fs | board.needs_start();
    pixel_ch.valid        <= 1'b1;
    pixel_ch.energy_value <= energy;
    pixel_ch.frame_start  <= start;
    do @(posedge clk); while (pixel_ch.ready !== 1'b1);
    board.note_pixel(energy, start);
  endtask

  task automatic wait_empty();
    pixel_ch.valid <= 1'b0;
    do @(posedge clk); while (board.pending() != 0);
  endtask

  // drain, let the pipeline settle, then write and read back image_width
  task automatic write_image_width(input logic [scem_pkg::CFG_W-1:0] v);
    logic [scem_pkg::APB_DATA_W-1:0] rd;
    wait_empty();
    repeat (4) @(posedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= WIDTH_ADDR;
    pwdata  <= scem_pkg::APB_DATA_W'(v);
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    board.set_span(v);
    pwrite  <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (pready !== 1'b1);
    rd = prdata;
    psel    <= 1'b0;
    penable <= 1'b0;
    if (rd[scem_pkg::CFG_W-1:0] !== v)
      board.report($sformatf("image_width read %h want %h", rd[scem_pkg::CFG_W-1:0], v));
  endtask

  function automatic logic [scem_pkg::CFG_W-1:0] pick_width();
    unique case ($urandom_range(0, 15))
      0:       return scem_pkg::CFG_W'($urandom_range(0, 1));
      1:       return scem_pkg::CFG_W'($urandom_range(4096, 8191));
      2, 3:    return scem_pkg::CFG_W'($urandom_range(13, 64));
      default: return scem_pkg::CFG_W'($urandom_range(2, 12));
    endcase
  endfunction

  function automatic logic [scem_pkg::ENERGY_W-1:0] draw_energy();
    unique case ($urandom_range(0, 3))
      1:       return scem_pkg::ENERGY_W'($urandom_range(0, 15));
      2:       return $urandom_range(0, 1) ? ENERGY_MAX : '0;
      default: return scem_pkg::ENERGY_W'($urandom);
    endcase
  endfunction

  initial begin
    int rand_left;
    int phase;
    int n;
    rst                   <= 1'b1;
    psel                  <= 1'b0;
    penable               <= 1'b0;
    pwrite                <= 1'b0;
    paddr                 <= '0;
    pwdata                <= '0;
    pixel_ch.valid        <= 1'b0;
    pixel_ch.energy_value <= '0;
    pixel_ch.frame_start  <= 1'b0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // no frame_start after reset: first row at the reset width
    send_pixel('0, 1'b0);
    send_pixel(ENERGY_MAX, 1'b0);
    send_pixel(20'h12345, 1'b0);

    // three columns: both edges and one middle column
    write_image_width(scem_pkg::CFG_W'(3));
    send_pixel(ENERGY_MAX, 1'b1);
    send_pixel('0, 1'b0);
    send_pixel(20'h00001, 1'b0);
    send_pixel('0, 1'b0);
    send_pixel(ENERGY_MAX, 1'b0);
    send_pixel(20'h00002, 1'b0);
    send_pixel(20'h00005, 1'b0);
    send_pixel(20'h00005, 1'b0);
    send_pixel(20'h00005, 1'b0);

    // width below the minimum acts as two
    write_image_width('0);
    send_pixel(20'h00007, 1'b1);
    send_pixel(20'h00003, 1'b0);
    send_pixel(ENERGY_MAX, 1'b0);
    send_pixel(20'h80000, 1'b0);

    // width above the line store clamps, then gets lowered in mid-row
    write_image_width('1);
    send_pixel(20'h00011, 1'b1);
    send_pixel(20'h00022, 1'b0);
    send_pixel(20'h00033, 1'b0);
    send_pixel(20'h00044, 1'b0);
    send_pixel(20'h00055, 1'b0);
    send_pixel(20'h00066, 1'b0);
    write_image_width(scem_pkg::CFG_W'(4));
    send_pixel(20'h00100, 1'b0);
    send_pixel(20'h00200, 1'b0);
    send_pixel(20'h00300, 1'b0);

    // full-rate run of maximum energies
    write_image_width(scem_pkg::CFG_W'(2));
    send_idle = 1'b0;
    recv_idle = 1'b0;
    send_pixel(ENERGY_MAX, 1'b1);
    repeat (39) send_pixel(ENERGY_MAX, 1'b0);

    rand_left = 440;
    phase     = 0;
    while (rand_left > 0) begin
      write_image_width(pick_width());
      send_idle = ($urandom_range(0, 3) != 0);
      recv_idle = ($urandom_range(0, 3) != 0);
      n = $urandom_range(20, 80);
      if (n > rand_left) n = rand_left;
      if (phase == 1) begin
        // hold the result side so the block backs up into the pixel side
        send_idle = 1'b0;
        hold_len  = 300;
        if (n < 50) n = 50;
      end
      for (int i = 0; i < n; i++) begin
        if (phase == 3 && i == n / 2) wait_empty();
        send_pixel(draw_energy(), (i == 0 && $urandom_range(0, 1) == 1) ||
                   $urandom_range(0, 49) == 0);
      end
      rand_left -= n;
      phase++;
    end

    wait_empty();
    repeat (10) @(posedge clk);
    if (board.errors == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/scem_pkg.sv
hw/rtl/scem_if.sv
hw/rtl/scem_ram.sv
hw/rtl/seam_cumulative_energy_map.sv
hw/rtl/scem_checker.sv
test/tb_seam_cumulative_energy_map.sv
